### hw/rtl/rtucrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtucrc_pkg
// Shared types, constants and the CRC-16 byte update for the RTU frame codec.
// ----------------------------------------------------------------------------
package rtucrc_pkg;

  localparam int unsigned MAX_FRAME = 256;
  localparam logic [7:0]  FRAME_LIM = 8'(MAX_FRAME - 3);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0]  NODE_ADDR_RST = 8'd1;
  localparam logic [7:0]  EXP_LEN_RST   = 8'd4;

  localparam logic [7:0]  BYTE_MAX   = 8'hFF;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [7:0]  EXC_CODE_N = 8'd12;

  // operation codes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_LINE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EXC    = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [1:0] ST_BADCRC = 2'd3;

  // configuration register indexes
  localparam logic CFG_NODE_ADDR = 1'b0;
  localparam logic CFG_EXP_LEN   = 1'b1;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       unk;
    logic       last;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [1:0] status, input logic unk);
    res_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.unk    = unk;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rtu_frame_codec_crc16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtu_frame_codec_crc16
// RTU framer / deframer with CRC-16 (preset 0xFFFF, reflected poly 0xA001).
// ----------------------------------------------------------------------------
// Input words: in_tuser selects send (0) or receive (1), in_tdata carries the
// byte, in_tlast marks the last query byte or the end of the line data.
// Each input word yields zero to four result words on the out_ channel:
// line bytes (address, query, CRC low, CRC high), payload bytes or a frame
// status. out_tlast flags the last result of one input word.
// Results are registered and appear in the cycle after the word is accepted.
// Throughput: one input word per cycle while each word gives at most one
// result and the receiver takes each result; a word giving more results holds
// the input while the single result port drains the 4-entry result buffer.
// Config writes (cfg_we) are registered; write only while idle.
// Reset: CRC to 0xFFFF, framer idle, result buffer empty, node address 1,
// expected length 4.
// Receiver stall: results wait in the buffer; the input is held off while
// more than one result is pending or the last one is not being taken.
// ----------------------------------------------------------------------------
module rtu_frame_codec_crc16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] operation
  input  wire logic        in_tlast,   // end_mark
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [9:8] frame_status,
                                       // [10] code_unknown, [15:11] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast,  // run_last
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SEND = 3'd1;
  localparam logic [2:0] PH_FUNC = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC1 = 3'd4;
  localparam logic [2:0] PH_CRC2 = 3'd5;
  localparam logic [2:0] PH_CODE = 3'd6;
  localparam logic [2:0] PH_SKIP = 3'd7;

  logic [7:0]  node_addr_r, node_addr_nxt;
  logic [7:0]  exp_len_r, exp_len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  first_crc_r, first_crc_nxt;
  logic [1:0]  skip_r, skip_nxt;

  rtucrc_pkg::res_t res_r   [rtucrc_pkg::MAX_RES];
  rtucrc_pkg::res_t res_nxt [rtucrc_pkg::MAX_RES];
  rtucrc_pkg::res_t res_v   [rtucrc_pkg::MAX_RES];
  logic [2:0]  res_cnt_r, res_cnt_nxt;
  logic [2:0]  n_v;

  logic        in_fire, out_fire;
  logic [7:0]  resp_lim;
  logic [15:0] crc_lo_src;

  assign out_tvalid = (res_cnt_r != 3'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = (res_cnt_r == 3'd0) || ((res_cnt_r == 3'd1) && out_tready);
  assign in_fire    = in_tvalid && in_tready;

  assign out_tuser = res_r[0].kind;
  assign out_tlast = res_r[0].last;
  assign out_tdata = {5'b0, res_r[0].unk, res_r[0].status, res_r[0].data};

  always_comb begin
    if (exp_len_r == 8'd0) begin
      resp_lim = 8'd1;
    end else if (exp_len_r > rtucrc_pkg::FRAME_LIM) begin
      resp_lim = rtucrc_pkg::FRAME_LIM;
    end else begin
      resp_lim = exp_len_r;
    end
  end

  // per-word framing step
  always_comb begin
    crc_nxt       = crc_r;
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    first_crc_nxt = first_crc_r;
    skip_nxt      = skip_r;
    crc_lo_src    = crc_r;
    n_v           = 3'd0;
    for (int i = 0; i < rtucrc_pkg::MAX_RES; i++) begin
      res_v[i] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_LINE, 8'h00, rtucrc_pkg::ST_OK, 1'b0);
    end

    if (in_tuser == rtucrc_pkg::OP_SEND) begin
      if (phase_r != PH_SEND) begin
        byte_cnt_nxt = 8'd0;
        skip_nxt     = 2'd0;
        res_v[0]     = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_LINE, node_addr_r,
                                          rtucrc_pkg::ST_OK, 1'b0);
        n_v          = 3'd1;
        crc_lo_src   = rtucrc_pkg::crc_byte(rtucrc_pkg::CRC_INIT, node_addr_r);
      end
      res_v[n_v[1:0]] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_LINE, in_tdata,
                                           rtucrc_pkg::ST_OK, 1'b0);
      n_v     = n_v + 3'd1;
      crc_nxt = rtucrc_pkg::crc_byte(crc_lo_src, in_tdata);
      if (byte_cnt_nxt < rtucrc_pkg::BYTE_MAX) begin
        byte_cnt_nxt = byte_cnt_nxt + 8'd1;
      end
      if (in_tlast || (byte_cnt_nxt >= rtucrc_pkg::FRAME_LIM)) begin
        res_v[n_v[1:0]] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_LINE, crc_nxt[7:0],
                                             rtucrc_pkg::ST_OK, 1'b0);
        n_v = n_v + 3'd1;
        res_v[n_v[1:0]] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_LINE, crc_nxt[15:8],
                                             rtucrc_pkg::ST_OK, 1'b0);
        n_v = n_v + 3'd1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_SEND;
      end
    end else if (in_tlast) begin
      if (phase_r == PH_SKIP) begin
        skip_nxt = 2'd0;
      end else begin
        res_v[0] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_STATUS, 8'h00,
                                      rtucrc_pkg::ST_SHORT, 1'b0);
        n_v = 3'd1;
      end
      phase_nxt = PH_IDLE;
    end else begin
      case (phase_r)
        PH_FUNC: begin
          crc_nxt = rtucrc_pkg::crc_byte(crc_r, in_tdata);
          if ((in_tdata & rtucrc_pkg::EXC_FLAG) != 8'h00) begin
            phase_nxt = PH_CODE;
          end else begin
            res_v[0] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_PAYLOAD, in_tdata,
                                          rtucrc_pkg::ST_OK, 1'b0);
            n_v          = 3'd1;
            byte_cnt_nxt = 8'd1;
            phase_nxt    = (resp_lim <= 8'd1) ? PH_CRC1 : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt  = rtucrc_pkg::crc_byte(crc_r, in_tdata);
          res_v[0] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_PAYLOAD, in_tdata,
                                        rtucrc_pkg::ST_OK, 1'b0);
          n_v = 3'd1;
          if (byte_cnt_r < rtucrc_pkg::BYTE_MAX) begin
            byte_cnt_nxt = byte_cnt_r + 8'd1;
          end
          if (byte_cnt_nxt >= resp_lim) begin
            phase_nxt = PH_CRC1;
          end
        end
        PH_CRC1: begin
          first_crc_nxt = in_tdata;
          phase_nxt     = PH_CRC2;
        end
        PH_CRC2: begin
          res_v[0] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_STATUS, 8'h00,
                       ((first_crc_r != crc_r[7:0]) || (in_tdata != crc_r[15:8])) ?
                       rtucrc_pkg::ST_BADCRC : rtucrc_pkg::ST_OK, 1'b0);
          n_v       = 3'd1;
          phase_nxt = PH_IDLE;
        end
        PH_CODE: begin
          res_v[0] = rtucrc_pkg::mk_res(rtucrc_pkg::KIND_STATUS, in_tdata,
                       rtucrc_pkg::ST_EXC,
                       (in_tdata == 8'h00) || (in_tdata >= rtucrc_pkg::EXC_CODE_N));
          n_v       = 3'd1;
          skip_nxt  = 2'd2;
          phase_nxt = PH_SKIP;
        end
        PH_SKIP: begin
          if (skip_r != 2'd0) begin
            skip_nxt = skip_r - 2'd1;
          end
          if (skip_nxt == 2'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          crc_nxt      = rtucrc_pkg::crc_byte(rtucrc_pkg::CRC_INIT, in_tdata);
          byte_cnt_nxt = 8'd0;
          skip_nxt     = 2'd0;
          phase_nxt    = PH_FUNC;
        end
      endcase
    end

    if (n_v != 3'd0) begin
      res_v[n_v[1:0] - 2'd1].last = 1'b1;
    end
  end

  // result buffer: load on accept, shift on drain
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    for (int i = 0; i < rtucrc_pkg::MAX_RES; i++) begin
      res_nxt[i] = res_r[i];
    end
    if (in_fire) begin
      for (int i = 0; i < rtucrc_pkg::MAX_RES; i++) begin
        res_nxt[i] = res_v[i];
      end
      res_cnt_nxt = n_v;
    end else if (out_fire) begin
      for (int i = 0; i < rtucrc_pkg::MAX_RES - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
      res_cnt_nxt = res_cnt_r - 3'd1;
    end
  end

  always_comb begin
    node_addr_nxt = node_addr_r;
    exp_len_nxt   = exp_len_r;
    if (cfg_we) begin
      case (cfg_index)
        rtucrc_pkg::CFG_NODE_ADDR: node_addr_nxt = cfg_wdata;
        rtucrc_pkg::CFG_EXP_LEN:   exp_len_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= rtucrc_pkg::NODE_ADDR_RST;
      exp_len_r   <= rtucrc_pkg::EXP_LEN_RST;
      crc_r       <= rtucrc_pkg::CRC_INIT;
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= 8'd0;
      first_crc_r <= 8'd0;
      skip_r      <= 2'd0;
      res_cnt_r   <= 3'd0;
    end else begin
      node_addr_r <= node_addr_nxt;
      exp_len_r   <= exp_len_nxt;
      res_cnt_r   <= res_cnt_nxt;
      if (in_fire) begin
        crc_r       <= crc_nxt;
        phase_r     <= phase_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        first_crc_r <= first_crc_nxt;
        skip_r      <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rtucrc_pkg::MAX_RES; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  // checks
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_cnt_r == 3'd1)) |-> out_tlast)
    else $error("final pending result not marked last");

  a_send_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == rtucrc_pkg::OP_SEND) && in_tlast) |=> (phase_r == PH_IDLE))
    else $error("framer not idle after last query byte");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != rtucrc_pkg::KIND_STATUS)) |->
      (out_tdata[10:8] == 3'd0))
    else $error("status bits set on a non-status result");

endmodule
`default_nettype wire

### tb/rtu_frame_codec_crc16_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_frame_codec_crc16_test
// Self-checking bench for the RTU frame codec. A behavioral model of the
// framer/deframer (CRC-16, phases, exception skip, length clamp) predicts the
// result words for every accepted input word. A monitor compares each result
// word with the oldest prediction. Directed frames come first, then random
// traffic, then long frames and more random response, query and noise
// traffic; the random traffic runs under three backpressure profiles.
// ----------------------------------------------------------------------------
module rtu_frame_codec_crc16_test;

  typedef enum logic [2:0] {
    FR_IDLE, FR_SEND, FR_FUNC, FR_DATA, FR_CRC1, FR_CRC2, FR_CODE, FR_SKIP
  } frame_phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] operation
  logic        in_tlast;   // end_mark
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] out_byte, [9:8] frame_status, [10] code_unknown
  logic [1:0]  out_tuser;  // [1:0] kind
  logic        out_tlast;  // run_last
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  rtu_frame_codec_crc16 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // model state
  logic [15:0]  lc_crc;
  frame_phase_t lc_phase;
  logic [7:0]   lc_count;
  logic [7:0]   lc_first;
  logic [1:0]   lc_skip;
  logic [7:0]   reg_node_addr;
  logic [7:0]   reg_exp_len;

  rtucrc_pkg::res_t pending_results[$];
  int   err_count = 0;
  int   words_sent = 0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ rtucrc_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] resp_len(input logic [7:0] len);
    if (len == 8'd0) return 8'd1;
    if (len > rtucrc_pkg::FRAME_LIM) return rtucrc_pkg::FRAME_LIM;
    return len;
  endfunction

  function automatic rtucrc_pkg::res_t res_word(input logic [1:0] kind, input logic [7:0] b,
                                                input logic [1:0] status, input logic unk);
    rtucrc_pkg::res_t r;
    r.kind   = kind;
    r.data   = b;
    r.status = status;
    r.unk    = unk;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic codec_reset();
    reg_node_addr = rtucrc_pkg::NODE_ADDR_RST;
    reg_exp_len   = rtucrc_pkg::EXP_LEN_RST;
    lc_crc        = rtucrc_pkg::CRC_INIT;
    lc_phase      = FR_IDLE;
    lc_count      = '0;
    lc_first      = '0;
    lc_skip       = '0;
  endtask

  // expected result words for one accepted input word
  task automatic codec_predict(input logic op, input logic [7:0] b, input logic endm);
    rtucrc_pkg::res_t words[rtucrc_pkg::MAX_RES];
    int   n;
    logic bad;
    n = 0;
    if (op == rtucrc_pkg::OP_SEND) begin
      if (lc_phase != FR_SEND) begin
        lc_crc   = rtucrc_pkg::CRC_INIT;
        lc_count = '0;
        lc_skip  = '0;
        lc_phase = FR_SEND;
        words[n] = res_word(rtucrc_pkg::KIND_LINE, reg_node_addr, rtucrc_pkg::ST_OK, 1'b0);
        n++;
        lc_crc = crc16_next(lc_crc, reg_node_addr);
      end
      words[n] = res_word(rtucrc_pkg::KIND_LINE, b, rtucrc_pkg::ST_OK, 1'b0);
      n++;
      lc_crc = crc16_next(lc_crc, b);
      if (lc_count < rtucrc_pkg::BYTE_MAX) lc_count++;
      if (endm || lc_count >= rtucrc_pkg::FRAME_LIM) begin
        words[n] = res_word(rtucrc_pkg::KIND_LINE, lc_crc[7:0], rtucrc_pkg::ST_OK, 1'b0);
        n++;
        words[n] = res_word(rtucrc_pkg::KIND_LINE, lc_crc[15:8], rtucrc_pkg::ST_OK, 1'b0);
        n++;
        lc_phase = FR_IDLE;
      end
    end else if (endm) begin
      if (lc_phase == FR_SKIP) begin
        lc_skip = '0;
      end else begin
        words[n] = res_word(rtucrc_pkg::KIND_STATUS, 8'h00, rtucrc_pkg::ST_SHORT, 1'b0);
        n++;
      end
      lc_phase = FR_IDLE;
    end else begin
      case (lc_phase)
        FR_FUNC: begin
          lc_crc = crc16_next(lc_crc, b);
          if ((b & rtucrc_pkg::EXC_FLAG) != 8'h00) begin
            lc_phase = FR_CODE;
          end else begin
            words[n] = res_word(rtucrc_pkg::KIND_PAYLOAD, b, rtucrc_pkg::ST_OK, 1'b0);
            n++;
            lc_count = 8'd1;
            lc_phase = (lc_count >= resp_len(reg_exp_len)) ? FR_CRC1 : FR_DATA;
          end
        end
        FR_DATA: begin
          lc_crc = crc16_next(lc_crc, b);
          words[n] = res_word(rtucrc_pkg::KIND_PAYLOAD, b, rtucrc_pkg::ST_OK, 1'b0);
          n++;
          if (lc_count < rtucrc_pkg::BYTE_MAX) lc_count++;
          if (lc_count >= resp_len(reg_exp_len)) lc_phase = FR_CRC1;
        end
        FR_CRC1: begin
          lc_first = b;
          lc_phase = FR_CRC2;
        end
        FR_CRC2: begin
          bad = (lc_first != lc_crc[7:0]) || (b != lc_crc[15:8]);
          words[n] = res_word(rtucrc_pkg::KIND_STATUS, 8'h00,
                              bad ? rtucrc_pkg::ST_BADCRC : rtucrc_pkg::ST_OK, 1'b0);
          n++;
          lc_phase = FR_IDLE;
        end
        FR_CODE: begin
          words[n] = res_word(rtucrc_pkg::KIND_STATUS, b, rtucrc_pkg::ST_EXC,
                              (b == 8'h00 || b >= rtucrc_pkg::EXC_CODE_N) ? 1'b1 : 1'b0);
          n++;
          lc_skip  = 2'd2;
          lc_phase = FR_SKIP;
        end
        FR_SKIP: begin
          if (lc_skip > 0) lc_skip--;
          if (lc_skip == 0) lc_phase = FR_IDLE;
        end
        default: begin
          lc_crc   = crc16_next(rtucrc_pkg::CRC_INIT, b);
          lc_count = '0;
          lc_skip  = '0;
          lc_phase = FR_FUNC;
        end
      endcase
    end
    if (n > 0) words[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_results.push_back(words[k]);
  endtask

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    rtucrc_pkg::res_t got;
    rtucrc_pkg::res_t want;
    out_tready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser;
      got.data   = out_tdata[7:0];
      got.status = out_tdata[9:8];
      got.unk    = out_tdata[10];
      got.last   = out_tlast;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result word: kind %0d byte %02h status %0d unk %0b last %0b",
                   got.kind, got.data, got.status, got.unk, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got != want || out_tdata[15:11] != 5'd0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: exp kind %0d byte %02h status %0d unk %0b last %0b",
                     want.kind, want.data, want.status, want.unk, want.last);
            $display("          got kind %0d byte %02h status %0d unk %0b last %0b pad %02h",
                     got.kind, got.data, got.status, got.unk, got.last, out_tdata[15:11]);
          end
        end
      end
    end
  end

  // valid stays high across back-to-back words; it is dropped only on an idle
  task automatic send_word(input logic op, input logic [7:0] b, input logic endm);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    in_tlast  <= endm;
    do @(posedge clk); while (!in_tready);
    codec_predict(op, b, endm);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_codec(input logic [7:0] node, input logic [7:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= rtucrc_pkg::CFG_NODE_ADDR;
    cfg_wdata <= node;
    @(posedge clk);
    cfg_index <= rtucrc_pkg::CFG_EXP_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_node_addr = node;
    reg_exp_len   = len;
  endtask

  task automatic send_query(input int nbytes, input bit with_end);
    for (int k = 0; k < nbytes; k++)
      send_word(rtucrc_pkg::OP_SEND, 8'($urandom), with_end && (k == nbytes - 1));
  endtask

  // address, function, body, CRC; lead is the first body byte; cut < 0: no early end
  task automatic send_response(input logic [7:0] addr, input logic [7:0] func,
                               input int nbody, input logic [7:0] lead,
                               input bit corrupt, input int cut);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    int          pos;
    frame.push_back(addr);
    frame.push_back(func);
    for (int k = 0; k < nbody; k++) frame.push_back((k == 0) ? lead : 8'($urandom));
    crc = rtucrc_pkg::CRC_INIT;
    foreach (frame[i]) crc = crc16_next(crc, frame[i]);
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(frame.size() - 1, 1);
      frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
    end
    foreach (frame[i]) begin
      if (i == cut) begin
        send_word(rtucrc_pkg::OP_RECV, 8'($urandom), 1'b1);
        return;
      end
      send_word(rtucrc_pkg::OP_RECV, frame[i], 1'b0);
    end
  endtask

  task automatic test_send_query();
    send_word(rtucrc_pkg::OP_SEND, 8'h00, 1'b0);
    send_word(rtucrc_pkg::OP_SEND, 8'hFF, 1'b1);
    // query dropped by a received word, which then opens a frame
    send_word(rtucrc_pkg::OP_SEND, 8'h12, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h34, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h00, 1'b1);
  endtask

  task automatic test_recv_status();
    program_codec(8'h11, 8'd1);
    send_response(8'h11, 8'h05, 0, 8'h00, 1'b0, -1);
    send_response(8'h11, 8'h05, 0, 8'h00, 1'b1, -1);
    send_response(8'h11, 8'h83, 1, 8'h00, 1'b0, -1);
    // end during the exception skip: no status
    send_word(rtucrc_pkg::OP_RECV, 8'h11, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h90, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h0C, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'hAA, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h00, 1'b1);
    send_word(rtucrc_pkg::OP_RECV, 8'h22, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'hFF, 1'b1);
    send_word(rtucrc_pkg::OP_RECV, 8'h00, 1'b1);
  endtask

  task automatic test_switch_direction();
    program_codec(8'hFF, 8'd0);
    send_word(rtucrc_pkg::OP_RECV, 8'h01, 1'b0);
    send_word(rtucrc_pkg::OP_RECV, 8'h7F, 1'b0);
    send_word(rtucrc_pkg::OP_SEND, 8'h80, 1'b1);
  endtask

  task automatic test_long_frames();
    program_codec(8'h00, 8'd255);
    send_query(253, 1'b0);
    send_query(1, 1'b1);
  endtask

  task automatic test_random(input int nwords);
    int         stop_at;
    int         sel;
    int         nbody;
    logic [7:0] addr;
    logic [7:0] code;
    stop_at = words_sent + nwords;
    while (words_sent < stop_at) begin
      program_codec(8'($urandom), 8'($urandom_range(10)));
      repeat ($urandom_range(5, 2)) begin
        sel  = $urandom_range(99);
        addr = 8'($urandom);
        if (sel < 40) begin
          nbody = resp_len(reg_exp_len) - 1;
          if ($urandom_range(9) == 0) nbody = nbody + 1;
          send_response(addr, 8'($urandom_range(8'h7F)), nbody, 8'($urandom),
                        $urandom_range(4) == 0,
                        ($urandom_range(9) == 0) ? $urandom_range(nbody + 3) : -1);
        end else if (sel < 55) begin
          code = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
          send_response(addr, 8'($urandom) | rtucrc_pkg::EXC_FLAG, 1, code,
                        1'b0, ($urandom_range(7) == 0) ? $urandom_range(4) : -1);
        end else if (sel < 80) begin
          send_query($urandom_range(6, 1), $urandom_range(9) != 0);
        end else begin
          repeat ($urandom_range(4, 1))
            send_word(1'($urandom), 8'($urandom), $urandom_range(3) == 0);
        end
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tuser   <= rtucrc_pkg::OP_SEND;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= rtucrc_pkg::CFG_NODE_ADDR;
    cfg_wdata  <= 8'h00;
    codec_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct  = 13;
    out_idle_pct = 70;
    test_send_query();
    test_recv_status();
    test_switch_direction();
    test_random(40);

    in_idle_pct  = 70;
    out_idle_pct = 13;
    test_long_frames();
    test_random(40);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random(40);

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rtucrc_pkg.sv
hw/rtl/rtu_frame_codec_crc16.sv
tb/rtu_frame_codec_crc16_test.sv
